FILE: rtl/ttee_pkg.sv
// Shared types, constants and saturation helpers for the tensor-train entry evaluator.
// Used by every module in rtl/ but ttee_ram; depends on nothing.
package ttee_pkg;

  localparam int MAX_DIMS    = 4;
  localparam int MAX_RANK    = 4;
  localparam int MODE_SIZE   = 16;
  localparam int CORE_W      = 2;
  localparam int RANK_W      = 2;
  localparam int MODE_W      = 4;
  localparam int DATA_W      = 32;
  localparam int QUERY_W     = 16;
  localparam int ND_W        = 3;
  localparam int ADDR_W      = CORE_W + MODE_W + RANK_W + RANK_W;
  localparam int STORE_DEPTH = MAX_DIMS * MODE_SIZE * MAX_RANK * MAX_RANK;
  localparam int PADDR_W     = 3;

  localparam logic          ACT_WRITE      = 1'b0;
  localparam logic          ACT_EVAL       = 1'b1;
  localparam logic          REG_NUM_DIMS   = 1'b0;
  localparam logic [ND_W-1:0] NUM_DIMS_RESET = ND_W'(4);

  typedef struct packed {
    logic               is_eval;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  value;
    logic [QUERY_W-1:0] query;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  // Clamp a 48-bit signed value into the signed 32-bit range.
  function automatic sat_t sat32(input logic signed [47:0] v);
    sat_t r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r.val = 32'h7FFF_FFFF;
      r.ovf = 1'b1;
    end else if (v < -48'sh0000_8000_0000) begin
      r.val = 32'h8000_0000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // Index of the last core in use, with zero and oversized counts clamped.
  function automatic logic [CORE_W-1:0] last_core(input logic [ND_W-1:0] nd);
    logic [CORE_W-1:0] r;
    if (nd == '0) begin
      r = '0;
    end else if (nd > ND_W'(MAX_DIMS)) begin
      r = CORE_W'(MAX_DIMS - 1);
    end else begin
      r = CORE_W'(nd - ND_W'(1));
    end
    return r;
  endfunction

endpackage

FILE: rtl/ttee_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ttee_front.sv
// Front end: takes input beats, decodes them into store writes or evaluations,
// and holds them in a two-entry queue. Depends on ttee_pkg.
module ttee_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic                            hold,
  input  logic                            action,
  input  logic [ttee_pkg::CORE_W-1:0]     core_sel,
  input  logic [ttee_pkg::RANK_W-1:0]     row_sel,
  input  logic [ttee_pkg::RANK_W-1:0]     col_sel,
  input  logic [ttee_pkg::MODE_W-1:0]     slice_sel,
  input  logic signed [ttee_pkg::DATA_W-1:0] entry_value,
  input  logic [ttee_pkg::QUERY_W-1:0]    query_index,
  output logic                            full,
  output logic                            item_valid,
  output ttee_pkg::item_t                 item,
  input  logic                            item_pop
);

  ttee_pkg::item_t entry_r [2];
  ttee_pkg::item_t dec;
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2) || hold;
  assign do_push    = push && !full;
  assign item_valid = (count_r != 2'd0);
  assign do_pop     = item_pop && item_valid;
  assign item       = entry_r[rd_ptr_r];

  always_comb begin
    dec.is_eval = (action == ttee_pkg::ACT_EVAL);
    dec.addr    = {core_sel, slice_sel, row_sel, col_sel};
    dec.value   = entry_value;
    dec.query   = query_index;
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

endmodule

FILE: rtl/ttee_back.sv
// Back end: owns the core store, clears it after reset, applies writes and runs
// evaluations through a single pipelined multiply-accumulate. Depends on ttee_pkg, ttee_ram.
module ttee_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  input  ttee_pkg::item_t                   item,
  output logic                              item_pop,
  input  logic [ttee_pkg::ND_W-1:0]         num_dims,
  output logic                              clearing,
  output logic                              res_valid,
  input  logic                              res_pop,
  output logic signed [ttee_pkg::DATA_W-1:0] entry_result,
  output logic                              overflow
);

  localparam int DW = ttee_pkg::DATA_W;
  localparam int AW = ttee_pkg::ADDR_W;

  ttee_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [3:0]                    cnt_r, cnt_nxt;
  logic [ttee_pkg::CORE_W-1:0]   core_r, core_nxt;
  logic                          init_r, init_nxt;
  logic [ttee_pkg::QUERY_W-1:0]  query_r, query_nxt;

  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [DW-1:0]                 wdata, rdata;
  logic [ttee_pkg::MODE_W-1:0]   slice;
  logic [ttee_pkg::RANK_W-1:0]   iss_i, iss_j;
  logic                          issue, start, copy, load;

  logic                          p1_v_r, p1_init_r, p2_v_r;
  logic [ttee_pkg::RANK_W-1:0]   p1_i_r, p1_j_r, p2_i_r, p2_j_r;
  logic signed [2*DW-1:0]        prod_r;
  logic signed [DW-1:0]          vec_r [ttee_pkg::MAX_RANK];
  logic signed [DW-1:0]          nxt_r [ttee_pkg::MAX_RANK];
  logic signed [DW-1:0]          acc_r;
  logic                          ovf_r;

  logic signed [47:0]            q_ext, sum_ext;
  ttee_pkg::sat_t                q_sat, sum_sat;

  logic                          out_v_r;
  logic signed [DW-1:0]          res_r;
  logic                          res_ovf_r;

  assign clearing     = (state_r == ttee_pkg::ST_CLEAR);
  assign res_valid    = out_v_r;
  assign entry_result = res_r;
  assign overflow     = res_ovf_r;

  assign slice = query_r[{core_r, 2'b00} +: ttee_pkg::MODE_W];
  assign iss_i = init_r ? cnt_r[1:0] : cnt_r[3:2];
  assign iss_j = init_r ? '0 : cnt_r[1:0];
  assign raddr = {core_r, slice, iss_i, iss_j};

  ttee_ram #(.WIDTH(DW), .DEPTH(ttee_pkg::STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    core_nxt  = core_r;
    init_nxt  = init_r;
    query_nxt = query_r;
    we        = 1'b0;
    waddr     = item.addr;
    wdata     = item.value;
    item_pop  = 1'b0;
    issue     = 1'b0;
    start     = 1'b0;
    copy      = 1'b0;
    load      = 1'b0;
    case (state_r)
      ttee_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(ttee_pkg::STORE_DEPTH - 1)) begin
          state_nxt = ttee_pkg::ST_IDLE;
        end
      end
      ttee_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item.is_eval) begin
            start     = 1'b1;
            query_nxt = item.query;
            core_nxt  = ttee_pkg::last_core(num_dims);
            init_nxt  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ttee_pkg::ST_ISSUE;
          end else begin
            we = 1'b1;
          end
        end
      end
      ttee_pkg::ST_ISSUE: begin
        issue   = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == (init_r ? 4'd3 : 4'd15)) begin
          state_nxt = ttee_pkg::ST_WAIT;
        end
      end
      ttee_pkg::ST_WAIT: begin
        if (!p1_v_r && !p2_v_r) begin
          copy = !init_r;
          if (core_r == '0) begin
            state_nxt = ttee_pkg::ST_FIN;
          end else begin
            core_nxt  = core_r - ttee_pkg::CORE_W'(1);
            init_nxt  = 1'b0;
            cnt_nxt   = '0;
            state_nxt = ttee_pkg::ST_ISSUE;
          end
        end
      end
      ttee_pkg::ST_FIN: begin
        if (!out_v_r || res_pop) begin
          load      = 1'b1;
          state_nxt = ttee_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttee_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttee_pkg::ST_CLEAR;
      clr_r   <= '0;
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      p1_v_r  <= issue;
      p2_v_r  <= p1_v_r && !p1_init_r;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (res_pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Product is floor-shifted by 16, saturated, then added to the running row sum.
  always_comb begin
    q_ext   = 48'(prod_r >>> 16);
    q_sat   = ttee_pkg::sat32(q_ext);
    sum_ext = 48'(signed'(p2_j_r == '0 ? '0 : acc_r)) + 48'(signed'(q_sat.val));
    sum_sat = ttee_pkg::sat32(sum_ext);
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    core_r    <= core_nxt;
    init_r    <= init_nxt;
    query_r   <= query_nxt;
    p1_init_r <= init_r;
    p1_i_r    <= iss_i;
    p1_j_r    <= iss_j;
    p2_i_r    <= p1_i_r;
    p2_j_r    <= p1_j_r;
    if (p1_v_r) begin
      if (p1_init_r) begin
        vec_r[p1_i_r] <= rdata;
      end else begin
        prod_r <= signed'(rdata) * vec_r[p1_j_r];
      end
    end
    if (copy) begin
      vec_r <= nxt_r;
    end
    if (p2_v_r) begin
      acc_r <= sum_sat.val;
      if (p2_j_r == ttee_pkg::RANK_W'(ttee_pkg::MAX_RANK - 1)) begin
        nxt_r[p2_i_r] <= sum_sat.val;
      end
    end
    if (start) begin
      ovf_r <= 1'b0;
    end else if (p2_v_r) begin
      ovf_r <= ovf_r | q_sat.ovf | sum_sat.ovf;
    end
    if (load) begin
      res_r     <= vec_r[0];
      res_ovf_r <= ovf_r;
    end
  end

endmodule

FILE: rtl/tensor_train_entry_eval.sv
// Tensor-train entry evaluator. After reset the core store (1024 words) is cleared,
// one word per cycle, and full stays high until the clear is done. A write beat is
// applied by the back end as it leaves the input queue. An evaluate beat with n cores in use
// runs a load pass over the last core, then one pass per earlier core, then offers its result:
// a single multiply-accumulate reads one store word per cycle through the one read port,
// so each later core pass issues 16 reads and then waits for the pipeline to drain.
// A two-entry queue in front and a result register behind let both sides stall freely.
// Depends on ttee_pkg, ttee_front, ttee_back, ttee_ram.
module tensor_train_entry_eval (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic                               in_action,
  input  logic [ttee_pkg::CORE_W-1:0]        in_core_sel,
  input  logic [ttee_pkg::RANK_W-1:0]        in_row_sel,
  input  logic [ttee_pkg::RANK_W-1:0]        in_col_sel,
  input  logic [ttee_pkg::MODE_W-1:0]        in_slice_sel,
  input  logic signed [ttee_pkg::DATA_W-1:0] in_entry_value,
  input  logic [ttee_pkg::QUERY_W-1:0]       in_query_index,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [ttee_pkg::DATA_W-1:0] out_entry_result,
  output logic                               out_overflow,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttee_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [ttee_pkg::ND_W-1:0] num_dims_r;
  logic            item_valid, item_pop, clearing, res_valid;
  ttee_pkg::item_t item;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ttee_pkg::REG_NUM_DIMS) ? 32'(num_dims_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= ttee_pkg::NUM_DIMS_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == ttee_pkg::REG_NUM_DIMS) begin
      num_dims_r <= pwdata[ttee_pkg::ND_W-1:0];
    end
  end

  ttee_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .hold        (clearing),
    .action      (in_action),
    .core_sel    (in_core_sel),
    .row_sel     (in_row_sel),
    .col_sel     (in_col_sel),
    .slice_sel   (in_slice_sel),
    .entry_value (in_entry_value),
    .query_index (in_query_index),
    .full        (full),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  ttee_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop),
    .num_dims     (num_dims_r),
    .clearing     (clearing),
    .res_valid    (res_valid),
    .res_pop      (pop && res_valid),
    .entry_result (out_entry_result),
    .overflow     (out_overflow)
  );

  assign empty = !res_valid;

endmodule

FILE: rtl/ttee_checker.sv
// Port-level checker for tensor_train_entry_eval, bound to the top level.
// Depends on ttee_pkg for field widths.
module ttee_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               push,
  input logic                               full,
  input logic                               in_action,
  input logic                               empty,
  input logic                               pop,
  input logic signed [ttee_pkg::DATA_W-1:0] out_entry_result,
  input logic                               out_overflow
);

  // Evaluate beats accepted but not yet delivered.
  logic [2:0] pend_r;
  logic       ev_in, ev_out;

  assign ev_in  = push && !full && (in_action == ttee_pkg::ACT_EVAL);
  assign ev_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(ev_in) - 3'(ev_out);
    end
  end

  a_reset_blocks: assert property (@(posedge clk) !rst_n |=> full && empty)
    else $error("queue not full and empty after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> pend_r != 3'd0)
    else $error("result beat without a pending evaluate");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_entry_result) && $stable(out_overflow))
    else $error("waiting result changed");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("more evaluates in flight than the block can hold");

endmodule

bind tensor_train_entry_eval ttee_checker u_ttee_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .push             (push),
  .full             (full),
  .in_action        (in_action),
  .empty            (empty),
  .pop              (pop),
  .out_entry_result (out_entry_result),
  .out_overflow     (out_overflow)
);

FILE: tb/tensor_train_entry_eval_checker.sv
// Checker for the tensor-train entry evaluator: watches both queue channels, keeps a
// shadow core store and register, predicts each evaluated entry and compares it.
// Depends on ttee_pkg.
`timescale 1ns / 1ps
module tensor_train_entry_eval_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  logic                               full,
  input  logic                               in_action,
  input  logic [ttee_pkg::CORE_W-1:0]        in_core_sel,
  input  logic [ttee_pkg::RANK_W-1:0]        in_row_sel,
  input  logic [ttee_pkg::RANK_W-1:0]        in_col_sel,
  input  logic [ttee_pkg::MODE_W-1:0]        in_slice_sel,
  input  logic signed [ttee_pkg::DATA_W-1:0] in_entry_value,
  input  logic [ttee_pkg::QUERY_W-1:0]       in_query_index,
  input  logic                               empty,
  input  logic                               pop,
  input  logic signed [ttee_pkg::DATA_W-1:0] out_entry_result,
  input  logic                               out_overflow,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ttee_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  input  logic                               pready,
  output int                                 fail_count,
  output int                                 pending_count
);

  typedef struct {
    logic signed [ttee_pkg::DATA_W-1:0] entry;
    logic                               ovf;
  } tt_entry_t;

  logic signed [ttee_pkg::DATA_W-1:0] shadow_store [ttee_pkg::STORE_DEPTH];
  logic [ttee_pkg::ND_W-1:0]          shadow_dims;
  tt_entry_t                          entry_queue [$];

  assign pending_count = entry_queue.size();

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                 inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [ttee_pkg::DATA_W-1:0] word_at(input int core,
                                                                 input int slice,
                                                                 input int row,
                                                                 input int col);
    return shadow_store[((core * ttee_pkg::MODE_SIZE + slice) * ttee_pkg::MAX_RANK + row)
                        * ttee_pkg::MAX_RANK + col];
  endfunction

  function automatic tt_entry_t eval_entry(input logic [ttee_pkg::QUERY_W-1:0] query);
    tt_entry_t res;
    logic signed [63:0] vec [ttee_pkg::MAX_RANK];
    logic signed [63:0] nxt [ttee_pkg::MAX_RANK];
    logic signed [63:0] acc;
    logic signed [63:0] prod;
    logic ovf;
    int n;
    int s;
    n = shadow_dims;
    if (n == 0) n = 1;
    if (n > ttee_pkg::MAX_DIMS) n = ttee_pkg::MAX_DIMS;
    ovf = 1'b0;
    s = (query >> (4 * (n - 1))) & 15;
    for (int r = 0; r < ttee_pkg::MAX_RANK; r++) vec[r] = word_at(n - 1, s, r, 0);
    for (int d = n - 2; d >= 0; d--) begin
      s = (query >> (4 * d)) & 15;
      for (int i = 0; i < ttee_pkg::MAX_RANK; i++) begin
        acc = 0;
        for (int j = 0; j < ttee_pkg::MAX_RANK; j++) begin
          // Arithmetic shift rounds toward minus infinity.
          prod = (64'(word_at(d, s, i, j)) * vec[j]) >>> 16;
          prod = clamp32(prod, ovf);
          acc = clamp32(acc + prod, ovf);
        end
        nxt[i] = acc;
      end
      vec = nxt;
    end
    res.entry = vec[0][31:0];
    res.ovf = ovf;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    tt_entry_t want;
    if (!rst_n) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      shadow_dims = ttee_pkg::NUM_DIMS_RESET;
      entry_queue.delete();
    end else begin
      // Result side first: a result never comes from a beat accepted in this cycle.
      if (pop && !empty) begin
        if (entry_queue.size() == 0) begin
          report_mismatch("unexpected result", out_entry_result, '0);
        end else begin
          want = entry_queue.pop_front();
          if (out_entry_result !== want.entry)
            report_mismatch("entry_result", out_entry_result, want.entry);
          if (out_overflow !== want.ovf)
            report_mismatch("overflow", 32'(out_overflow), 32'(want.ovf));
        end
      end
      if (push && !full) begin
        if (in_action == ttee_pkg::ACT_WRITE)
          shadow_store[{in_core_sel, in_slice_sel, in_row_sel, in_col_sel}] = in_entry_value;
        else
          entry_queue.push_back(eval_entry(in_query_index));
      end
      if (psel && penable && pwrite && pready
          && paddr == ttee_pkg::PADDR_W'(4 * ttee_pkg::REG_NUM_DIMS))
        shadow_dims = pwdata[ttee_pkg::ND_W-1:0];
    end
  end
endmodule

FILE: tb/tensor_train_entry_eval_test.sv
// Top of the tensor-train entry evaluator testbench: clock, reset, stimulus, register
// writes, flow control and the verdict. Depends on ttee_pkg, the block and the checker.
`timescale 1ns / 1ps
module tensor_train_entry_eval_test;

  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_action = 1'b0;
  logic [ttee_pkg::CORE_W-1:0] in_core_sel = '0;
  logic [ttee_pkg::RANK_W-1:0] in_row_sel = '0;
  logic [ttee_pkg::RANK_W-1:0] in_col_sel = '0;
  logic [ttee_pkg::MODE_W-1:0] in_slice_sel = '0;
  logic signed [ttee_pkg::DATA_W-1:0] in_entry_value = '0;
  logic [ttee_pkg::QUERY_W-1:0] in_query_index = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [ttee_pkg::DATA_W-1:0] out_entry_result;
  logic out_overflow;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ttee_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending_count;
  int quiet_cycles = 0;
  int pop_wait = 0;
  bit hold_results = 1'b0;

  always #4 clk = ~clk;

  tensor_train_entry_eval dut (.*);
  tensor_train_entry_eval_checker checker_i (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 4);
    return 0;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  task automatic send_beat(input logic act, input logic [1:0] core, input logic [1:0] row,
                           input logic [1:0] col, input logic [3:0] slice,
                           input logic [31:0] value, input logic [15:0] query);
    int gap;
    push <= 1'b1;
    in_action <= act;
    in_core_sel <= core;
    in_row_sel <= row;
    in_col_sel <= col;
    in_slice_sel <= slice;
    in_entry_value <= value;
    in_query_index <= query;
    do @(posedge clk); while (full);
    gap = gap_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_write();
    send_beat(ttee_pkg::ACT_WRITE, 2'($urandom), 2'($urandom), 2'($urandom), 4'($urandom),
              rand_value(), 16'($urandom));
  endtask

  task automatic send_eval(input logic [15:0] query);
    send_beat(ttee_pkg::ACT_EVAL, 2'($urandom), 2'($urandom), 2'($urandom), 4'($urandom),
              $urandom, query);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // A trailing write may still be in the back end.
    repeat (80) @(posedge clk);
  endtask

  task automatic set_dims(input logic [ttee_pkg::ND_W-1:0] dims);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ttee_pkg::PADDR_W'(4 * ttee_pkg::REG_NUM_DIMS);
    pwdata <= {$urandom} & ~32'h7 | 32'(dims);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: mostly ready, with short random gaps and now and then a long one.
  always @(posedge clk) begin
    if (!rst_n || hold_results) begin
      pop <= 1'b0;
    end else if (pop_wait > 0) begin
      pop <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      pop <= 1'b0;
      pop_wait <= $urandom_range(20, 80);
    end else begin
      pop <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Directed part: zero store, extremes, selectors, dimension clamps.
    send_eval(16'h0000);
    send_beat(ttee_pkg::ACT_WRITE, 2'd3, 2'd0, 2'd0, 4'd15, 32'h0001_0000, 16'h0);
    send_eval(16'hF000);
    send_beat(ttee_pkg::ACT_WRITE, 2'd0, 2'd0, 2'd3, 4'd0, 32'h7FFF_FFFF, 16'hFFFF);
    send_beat(ttee_pkg::ACT_WRITE, 2'd1, 2'd3, 2'd0, 4'd0, 32'h7FFF_FFFF, 16'h0);
    send_beat(ttee_pkg::ACT_WRITE, 2'd2, 2'd0, 2'd0, 4'd0, 32'h8000_0000, 16'h0);
    send_beat(ttee_pkg::ACT_WRITE, 2'd3, 2'd0, 2'd0, 4'd0, 32'h8000_0000, 16'h0);
    send_eval(16'h0000);
    send_eval(16'hFFFF);
    set_dims(3'd0);
    send_beat(ttee_pkg::ACT_WRITE, 2'd0, 2'd0, 2'd0, 4'd5, 32'hFFFF_8000, 16'h0);
    send_eval(16'h0005);
    set_dims(3'd7);
    send_eval(16'h0000);
    set_dims(3'd1);
    send_eval(16'h0005);
    for (int p = 0; p < 10; p++) begin
      set_dims(3'($urandom_range(1, 4)));
      if (p == 5) set_dims(3'($urandom_range(5, 7)));
      // Mostly writes to the used slices, then a burst of evaluations.
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 2) == 0) send_eval(16'($urandom_range(0, 3) * 16'h1111));
        else if ($urandom_range(0, 9) == 0) send_eval(16'($urandom));
        else
          send_beat(ttee_pkg::ACT_WRITE, 2'($urandom), 2'($urandom), 2'($urandom),
                    4'($urandom_range(0, 3)), rand_value(), 16'($urandom));
      end
      for (int i = 0; i < 35; i++) begin
        if ($urandom_range(0, 3) == 0) send_write();
        else send_eval(16'($urandom) & 16'h3333);
      end
      if (p == 3) begin
        hold_results = 1'b1;
        fork
          begin
            repeat (1500) @(posedge clk);
            hold_results = 1'b0;
          end
          for (int i = 0; i < 12; i++) send_eval(16'($urandom));
        join
      end
    end
    drain();
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
